### sv/hex_record_stream_parser_assert.svh
// ---------------------------------------------------------------------------
// Hex record stream parser assertion macros
// Clocked property checks shared by the parser modules.
// ---------------------------------------------------------------------------
`ifndef HEX_RECORD_STREAM_PARSER_ASSERT_SVH
`define HEX_RECORD_STREAM_PARSER_ASSERT_SVH

// check a property at every edge outside reset
`define HRSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// check a property at every edge, reset included
`define HRSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

### sv/hrsp_pkg.sv
// ---------------------------------------------------------------------------
// Hex record stream parser package
// Types, character codes and the hex digit decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrsp_pkg;

    localparam logic [7:0] CH_COLON        = 8'h3A;
    localparam logic [7:0] CH_CR           = 8'h0D;
    localparam logic [7:0] CH_LF           = 8'h0A;
    localparam logic [7:0] TYPE_EXT_LINEAR = 8'h04;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_COUNT = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_FRAME = 2'd2
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] character;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  value;
        logic [7:0]  record_type;
        logic [7:0]  byte_count;
        logic        bad_digit;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        h.ok     = 1'b1;
        h.nibble = 4'h0;
        if (c inside {[8'h30:8'h39]})
        begin
            h.nibble = 4'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            h.nibble = 4'(c - 8'h57);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            h.nibble = 4'(c - 8'h37);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### sv/hrsp_char_if.sv
// ---------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one ASCII character per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hrsp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

`default_nettype wire

### sv/hrsp_result_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one parser result per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hrsp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  value;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
    logic        bad_digit;

    modport source (output valid, output kind, output address, output value,
                    output record_type, output byte_count, output bad_digit,
                    input ready);
    modport sink (input valid, input kind, input address, input value,
                  input record_type, input byte_count, input bad_digit,
                  output ready);
endinterface

`default_nettype wire

### sv/hrsp_in_stage.sv
// ---------------------------------------------------------------------------
// Hex record stream parser input register
// Holds one accepted character until the parser steps on it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrsp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    hrsp_char_if.sink       chars,
    input  wire logic       advance,
    output hrsp_pkg::in_word_t word
);
    import hrsp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       take;

    assign chars.ready = !valid_reg || advance;
    assign take        = chars.valid && chars.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= chars.character;
        end
    end

    assign word.valid     = valid_reg;
    assign word.character = char_reg;

endmodule

`default_nettype wire

### sv/hrsp_parser.sv
// ---------------------------------------------------------------------------
// Hex record stream parser core
// Record state machine: one character step per cycle while step is high, at most one result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hex_record_stream_parser_assert.svh"

module hrsp_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire hrsp_pkg::in_word_t word,
    input  wire logic        step,
    output logic             res_valid,
    output hrsp_pkg::result_t res
);
    import hrsp_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [1:0]  nibble_reg, nibble_next;
    logic [7:0]  count_reg,  count_next;
    logic [15:0] low_reg,    low_next;
    logic [7:0]  type_reg,   type_next;
    logic [7:0]  index_reg,  index_next;
    logic [7:0]  acc_reg,    acc_next;
    logic [15:0] upper_reg,  upper_next;
    logic [15:0] pending_reg, pending_next;
    logic        digit_reg,  digit_next;

    hex_digit_t  hv;
    logic [7:0]  full;
    logic [31:0] base;
    logic [7:0]  index_inc;

    assign hv        = hex_decode(word.character);
    assign full      = acc_reg | {4'h0, hv.nibble};
    assign base      = {upper_reg, low_reg};
    assign index_inc = index_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        nibble_next  = nibble_reg;
        count_next   = count_reg;
        low_next     = low_reg;
        type_next    = type_reg;
        index_next   = index_reg;
        acc_next     = acc_reg;
        upper_next   = upper_reg;
        pending_next = pending_reg;
        digit_next   = digit_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (step)
        begin
            case (phase_reg)
                PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK:
                begin
                    digit_next = digit_reg | !hv.ok;
                    if (phase_reg == PH_ADDR)
                    begin
                        low_next = {low_reg[11:0], hv.nibble};
                        if (nibble_reg == 2'd3)
                        begin
                            nibble_next = 2'd0;
                            phase_next  = PH_TYPE;
                        end
                        else
                        begin
                            nibble_next = nibble_reg + 2'd1;
                        end
                    end
                    else if (nibble_reg == 2'd0)
                    begin
                        acc_next    = {hv.nibble, 4'h0};
                        nibble_next = 2'd1;
                    end
                    else
                    begin
                        acc_next    = full;
                        nibble_next = 2'd0;
                        case (phase_reg)
                            PH_COUNT:
                            begin
                                count_next = full;
                                phase_next = PH_ADDR;
                            end
                            PH_TYPE:
                            begin
                                type_next  = full;
                                phase_next = (count_reg == 8'd0) ? PH_CHECK : PH_DATA;
                            end
                            PH_DATA:
                            begin
                                if (index_reg == 8'd0)
                                begin
                                    pending_next = {full, pending_reg[7:0]};
                                end
                                else if (index_reg == 8'd1)
                                begin
                                    pending_next = {pending_reg[15:8], full};
                                end
                                res_valid       = 1'b1;
                                res.kind        = KIND_DATA;
                                res.address     = base + {24'h0, index_reg};
                                res.value       = full;
                                res.record_type = type_reg;
                                res.byte_count  = count_reg;
                                res.bad_digit   = digit_next;
                                index_next      = index_inc;
                                if (index_inc >= count_reg)
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            default:
                            begin
                                res_valid       = 1'b1;
                                res.kind        = KIND_END;
                                res.address     = base;
                                res.value       = full;
                                res.record_type = type_reg;
                                res.byte_count  = count_reg;
                                res.bad_digit   = digit_next;
                                if (type_reg == TYPE_EXT_LINEAR)
                                begin
                                    upper_next = pending_reg;
                                end
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (word.character == CH_COLON)
                    begin
                        phase_next   = PH_COUNT;
                        nibble_next  = 2'd0;
                        count_next   = 8'd0;
                        low_next     = 16'd0;
                        type_next    = 8'd0;
                        index_next   = 8'd0;
                        acc_next     = 8'd0;
                        pending_next = 16'd0;
                        digit_next   = 1'b0;
                    end
                    else if (word.character != CH_CR && word.character != CH_LF)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_FRAME;
                        res.value = word.character;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            nibble_reg  <= 2'd0;
            count_reg   <= 8'd0;
            low_reg     <= 16'd0;
            type_reg    <= 8'd0;
            index_reg   <= 8'd0;
            acc_reg     <= 8'd0;
            upper_reg   <= 16'd0;
            pending_reg <= 16'd0;
            digit_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            nibble_reg  <= nibble_next;
            count_reg   <= count_next;
            low_reg     <= low_next;
            type_reg    <= type_next;
            index_reg   <= index_next;
            acc_reg     <= acc_next;
            upper_reg   <= upper_next;
            pending_reg <= pending_next;
            digit_reg   <= digit_next;
        end
    end

    `HRSP_ASSERT(a_addr_silent, (step && phase_reg == PH_ADDR) |-> !res_valid, "address digit gave a result")
    `HRSP_ASSERT(a_data_phase, (res_valid && res.kind == KIND_DATA) |-> phase_reg == PH_DATA, "data byte outside payload")
    `HRSP_ASSERT(a_data_count, phase_reg == PH_DATA |-> count_reg != 8'd0, "payload phase with zero count")
    `HRSP_ASSERT(a_idle_step, (step && phase_reg == PH_IDLE) |=> (phase_reg == PH_IDLE || phase_reg == PH_COUNT), "idle left to a wrong phase")

endmodule

`default_nettype wire

### sv/hrsp_out_fifo.sv
// ---------------------------------------------------------------------------
// Hex record stream parser output buffer
// Two-word result queue decoupling the parser from the result sink.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hex_record_stream_parser_assert.svh"

module hrsp_out_fifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire hrsp_pkg::result_t push_word,
    output logic             space,
    hrsp_result_if.source    results
);
    import hrsp_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;
    result_t    head;

    assign space = (count_reg != 2'd2);
    assign pop   = results.valid && results.ready;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    assign results.valid       = (count_reg != 2'd0);
    assign results.kind        = head.kind;
    assign results.address     = head.address;
    assign results.value       = head.value;
    assign results.record_type = head.record_type;
    assign results.byte_count  = head.byte_count;
    assign results.bad_digit   = head.bad_digit;

    `HRSP_ASSERT(a_no_overflow, !(push && count_reg == 2'd2), "push into full buffer")
    `HRSP_ASSERT(a_count_range, count_reg != 2'd3, "buffer count out of range")
    `HRSP_ASSERT(a_pop_count, (pop && !push) |=> count_reg == $past(count_reg) - 2'd1, "pop lost track of count")
    `HRSP_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> count_reg == 2'd0, "buffer not empty in reset")

endmodule

`default_nettype wire

### sv/hex_record_stream_parser.sv
// ---------------------------------------------------------------------------
// Hex record stream parser
// Parses colon-framed hex records from a character stream into data bytes,
// record ends and framing errors.
//
//   channel   dir   word
//   chars     in    character[7:0]
//   results   out   kind, address, value, record_type, byte_count, bad_digit
//
// One character per cycle sustained while the result buffer has space; a result
// is written to the buffer when its character steps from the input register.
// With space free, the record state machine steps once per cycle from the input register.
// Reset clears the state machine, upper address and both buffers.
// A stalled result sink fills the two-word result buffer, then holds the
// input register, then drops chars.ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hex_record_stream_parser (
    input  wire logic     clk,
    input  wire logic     rst_n,
    hrsp_char_if.sink     chars,
    hrsp_result_if.source results
);
    import hrsp_pkg::*;

    in_word_t word;
    logic     space;
    logic     step;
    logic     res_valid;
    result_t  res;

    assign step = word.valid && space;

    hrsp_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .advance (step),
        .word    (word)
    );

    hrsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .step      (step),
        .res_valid (res_valid),
        .res       (res)
    );

    hrsp_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_word (res),
        .space     (space),
        .results   (results)
    );

endmodule

`default_nettype wire

### tb/sv/hex_record_stream_parser_test.sv
// ---------------------------------------------------------------------------
// Hex record stream parser testbench
// Feeds a short scripted stream, then random hex records mixed with noise
// and broken records, with bursty sending and a stalling result sink.
// Every result word is checked against typed-in values or a cycle-free parser model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_record_stream_parser_test;

    import hrsp_pkg::*;

    localparam int SCRIPT_LEN   = 28;
    localparam int RANDOM_CHARS = 1600;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 100;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        result_t    want;
    } stream_word_t;

    logic clk = 1'b0;
    logic rst_n;

    hrsp_char_if   chars_bus ();
    hrsp_result_if results_bus ();

    hex_record_stream_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_bus),
        .results (results_bus)
    );

    always #5 clk = ~clk;

    // scripted words; results typed in where obvious, else from the model
    stream_word_t script [SCRIPT_LEN] = '{
        '{8'h00, 1'b1, '{KIND_FRAME, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'hFF, 1'b1, '{KIND_FRAME, 32'h0000_0000, 8'hFF, 8'h00, 8'h00, 1'b0}},
        '{CH_CR, 1'b0, '0},
        '{CH_LF, 1'b0, '0},
        '{CH_COLON, 1'b0, '0},
        '{"0", 1'b0, '0},
        '{"1", 1'b0, '0},
        '{"f", 1'b0, '0},
        '{"f", 1'b0, '0},
        '{"f", 1'b0, '0},
        '{"f", 1'b0, '0},
        '{"0", 1'b0, '0},
        '{"4", 1'b0, '0},
        '{"F", 1'b0, '0},
        '{"F", 1'b1, '{KIND_DATA, 32'h0000_FFFF, 8'hFF, 8'h04, 8'h01, 1'b0}},
        '{"c", 1'b0, '0},
        '{"d", 1'b1, '{KIND_END, 32'h0000_FFFF, 8'hCD, 8'h04, 8'h01, 1'b0}},
        '{CH_COLON, 1'b0, '0},
        '{"0", 1'b0, '0},
        '{"0", 1'b0, '0},
        '{"F", 1'b0, '0},
        '{"F", 1'b0, '0},
        '{"F", 1'b0, '0},
        '{"F", 1'b0, '0},
        '{"g", 1'b0, '0},
        '{CH_COLON, 1'b0, '0},
        '{CH_LF, 1'b0, '0},
        '{"A", 1'b1, '{KIND_END, 32'hFF00_FFFF, 8'h0A, 8'h00, 8'h00, 1'b1}}
    };

    stream_word_t char_stream [$];
    result_t      expected_results [$];
    int           chars_taken = 0;
    int           mismatches = 0;

    // parser model state
    phase_t      parse_phase = PH_IDLE;
    logic [1:0]  nib_pos = '0;
    logic [7:0]  rec_count = '0;
    logic [15:0] rec_low_addr = '0;
    logic [7:0]  rec_type = '0;
    logic [7:0]  rec_byte_idx = '0;
    logic [7:0]  byte_acc = '0;
    logic [15:0] upper_addr = '0;
    logic [15:0] next_upper = '0;
    logic        digit_bad = 1'b0;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        if (c >= "0" && c <= "9")
        begin
            return 4'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return 4'(c - "a" + 8'd10);
        end
        if (c >= "A" && c <= "F")
        begin
            return 4'(c - "A" + 8'd10);
        end
        ok = 1'b0;
        return 4'h0;
    endfunction

    function automatic result_t record_result(input kind_t k, input logic [31:0] a,
                                              input logic [7:0] v);
        result_t r;
        r.kind        = k;
        r.address     = a;
        r.value       = v;
        r.record_type = rec_type;
        r.byte_count  = rec_count;
        r.bad_digit   = digit_bad;
        return r;
    endfunction

    function automatic logic parse_char(input logic [7:0] c, output result_t r);
        logic [3:0]  d;
        logic        ok;
        logic [7:0]  full;
        logic [31:0] base;
        r = '0;
        if (!(parse_phase inside {PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK}))
        begin
            parse_phase = PH_IDLE;
            if (c == CH_COLON)
            begin
                parse_phase  = PH_COUNT;
                nib_pos      = '0;
                rec_count    = '0;
                rec_low_addr = '0;
                rec_type     = '0;
                rec_byte_idx = '0;
                byte_acc     = '0;
                next_upper   = '0;
                digit_bad    = 1'b0;
                return 1'b0;
            end
            if (c == CH_CR || c == CH_LF)
            begin
                return 1'b0;
            end
            r.kind  = KIND_FRAME;
            r.value = c;
            return 1'b1;
        end
        d = hex_nibble(c, ok);
        if (!ok)
        begin
            digit_bad = 1'b1;
        end
        if (parse_phase == PH_ADDR)
        begin
            rec_low_addr = {rec_low_addr[11:0], d};
            if (nib_pos == 2'd3)
            begin
                nib_pos     = '0;
                parse_phase = PH_TYPE;
            end
            else
            begin
                nib_pos = nib_pos + 2'd1;
            end
            return 1'b0;
        end
        if (nib_pos == 2'd0)
        begin
            byte_acc = {d, 4'h0};
            nib_pos  = 2'd1;
            return 1'b0;
        end
        full     = byte_acc | {4'h0, d};
        byte_acc = full;
        nib_pos  = '0;
        base     = {upper_addr, 16'h0000} + {16'h0000, rec_low_addr};
        case (parse_phase)
            PH_COUNT:
            begin
                rec_count   = full;
                parse_phase = PH_ADDR;
                return 1'b0;
            end
            PH_TYPE:
            begin
                rec_type    = full;
                parse_phase = (rec_count == 8'h00) ? PH_CHECK : PH_DATA;
                return 1'b0;
            end
            PH_DATA:
            begin
                if (rec_byte_idx == 8'd0)
                begin
                    next_upper[15:8] = full;
                end
                else if (rec_byte_idx == 8'd1)
                begin
                    next_upper[7:0] = full;
                end
                r = record_result(KIND_DATA, base + {24'h0, rec_byte_idx}, full);
                rec_byte_idx = rec_byte_idx + 8'd1;
                if (rec_byte_idx >= rec_count)
                begin
                    parse_phase = PH_CHECK;
                end
                return 1'b1;
            end
            default:
            begin
                r = record_result(KIND_END, base, full);
                if (rec_type == TYPE_EXT_LINEAR)
                begin
                    upper_addr = next_upper;
                end
                parse_phase = PH_IDLE;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic add_word(input logic [7:0] c);
        stream_word_t w;
        w       = '0;
        w.ch    = c;
        char_stream.push_back(w);
    endtask

    task automatic add_hex_byte(input logic [7:0] b);
        logic [3:0] n;
        logic [7:0] c;
        logic       ok;
        for (int i = 1; i >= 0; i--)
        begin
            n = b[i*4 +: 4];
            if ($urandom_range(0, 49) == 0)
            begin
                do
                begin
                    c = 8'($urandom_range(0, 255));
                    void'(hex_nibble(c, ok));
                end
                while (ok);
            end
            else if (n < 4'd10)
            begin
                c = "0" + 8'(n);
            end
            else
            begin
                c = ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
            end
            add_word(c);
        end
    endtask

    task automatic add_record();
        int         pick;
        logic [7:0] count;
        logic [7:0] rtype;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            count = 8'd0;
        end
        else if (pick < 80)
        begin
            count = 8'($urandom_range(1, 6));
        end
        else if (pick < 98)
        begin
            count = 8'($urandom_range(7, 32));
        end
        else
        begin
            count = 8'($urandom_range(200, 255));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            rtype = 8'h00;
        end
        else if (pick < 75)
        begin
            rtype = TYPE_EXT_LINEAR;
        end
        else if (pick < 80)
        begin
            rtype = 8'h01;
        end
        else
        begin
            rtype = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 99);
        addr = (pick < 25) ? 16'hFFFF : (pick < 35) ? 16'h0000 : 16'($urandom_range(0, 65535));
        add_word(CH_COLON);
        add_hex_byte(count);
        add_hex_byte(addr[15:8]);
        add_hex_byte(addr[7:0]);
        add_hex_byte(rtype);
        for (int i = 0; i < count; i++)
        begin
            add_hex_byte(($urandom_range(0, 9) < 3) ? 8'hFF : 8'($urandom_range(0, 255)));
        end
        add_hex_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2))
        begin
            add_word($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
    endtask

    task automatic build_stream();
        int pick;
        foreach (script[i])
        begin
            char_stream.push_back(script[i]);
        end
        while (char_stream.size() < SCRIPT_LEN + RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                add_record();
            end
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    add_word(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                // broken record: colon, then 1 to 10 random characters
                add_word(CH_COLON);
                repeat ($urandom_range(1, 10))
                begin
                    add_word(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        end
        mismatches++;
    endtask

    // sender: bursts of words separated by random gaps
    int send_pos = 0;
    int burst_left = 16;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_bus.valid     <= 1'b0;
            chars_bus.character <= 8'h00;
        end
        else
        begin
            if (chars_bus.valid && chars_bus.ready)
            begin
                send_pos   = send_pos + 1;
                burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                end
            end
            if (!chars_bus.valid || chars_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    chars_bus.valid <= 1'b0;
                end
                else if (send_pos < char_stream.size())
                begin
                    chars_bus.valid     <= 1'b1;
                    chars_bus.character <= char_stream[send_pos].ch;
                end
                else
                begin
                    chars_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern re-picked at random among four modes, one long hold-off
    int  sink_cycle = 0;
    int  sink_mode = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_bus.ready <= 1'b0;
        end
        else
        begin
            sink_cycle = sink_cycle + 1;
            if (sink_cycle % 256 == 0)
            begin
                sink_mode = $urandom_range(0, 3);
            end
            if (!hold_done && chars_taken >= 400)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                results_bus.ready <= 1'b0;
            end
            else
            begin
                case (sink_mode)
                    0: results_bus.ready <= 1'b1;
                    1: results_bus.ready <= (sink_cycle % 4 != 3);
                    2: results_bus.ready <= 1'($urandom_range(0, 1));
                    default: results_bus.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : take_chars
        result_t      predicted;
        logic         produced;
        stream_word_t w;
        if (rst_n && chars_bus.valid && chars_bus.ready)
        begin
            produced = parse_char(chars_bus.character, predicted);
            w = char_stream[chars_taken];
            if (w.typed)
            begin
                expected_results.push_back(w.want);
            end
            else if (produced)
            begin
                expected_results.push_back(predicted);
            end
            chars_taken = chars_taken + 1;
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && results_bus.valid && results_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result kind", 32'(results_bus.kind), 32'hX);
            end
            else
            begin
                want = expected_results.pop_front();
                if (results_bus.kind !== want.kind)
                begin
                    report_mismatch("kind", 32'(results_bus.kind), 32'(want.kind));
                end
                if (results_bus.address !== want.address)
                begin
                    report_mismatch("address", results_bus.address, want.address);
                end
                if (results_bus.value !== want.value)
                begin
                    report_mismatch("value", 32'(results_bus.value), 32'(want.value));
                end
                if (results_bus.record_type !== want.record_type)
                begin
                    report_mismatch("record_type", 32'(results_bus.record_type),
                                    32'(want.record_type));
                end
                if (results_bus.byte_count !== want.byte_count)
                begin
                    report_mismatch("byte_count", 32'(results_bus.byte_count),
                                    32'(want.byte_count));
                end
                if (results_bus.bad_digit !== want.bad_digit)
                begin
                    report_mismatch("bad_digit", 32'(results_bus.bad_digit),
                                    32'(want.bad_digit));
                end
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (chars_bus.valid && chars_bus.ready)
            || (results_bus.valid && results_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        chars_bus.valid       = 1'b0;
        chars_bus.character   = 8'h00;
        results_bus.ready     = 1'b0;
        build_stream();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (chars_taken < char_stream.size() || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
